// File: rtl/sces_pkg.sv
// Package for the color Sobel edge stream: config and queue entry types,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps
package sces_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_RED    = 3'd2;
  localparam logic [2:0] CFG_GREEN  = 3'd3;
  localparam logic [2:0] CFG_BLUE   = 3'd4;

  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;
  localparam logic [8:0]  RED_RST    = 9'd77;
  localparam logic [8:0]  GREEN_RST  = 9'd150;
  localparam logic [8:0]  BLUE_RST   = 9'd29;

  typedef struct packed {
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [8:0]  weight_red;
    logic [8:0]  weight_green;
    logic [8:0]  weight_blue;
  } cfg_t;

  // win[row][col]: row 0 top, col 0 left
  typedef struct packed {
    logic [2:0][2:0][7:0] win;
    logic [23:0]          color;
    logic [10:0]          col;
    logic [11:0]          row;
    logic                 done;
    logic                 border;
  } entry_t;

endpackage

// File: rtl/sces_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sces_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// File: rtl/sces_queue.sv
// Short queue of window entries between front and back.
// Depends on sces_pkg.
`timescale 1ns / 1ps
module sces_queue import sces_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o
);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  entry_t            slot_q [QUEUE_DEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [CNTW-1:0]   cnt_q;

  assign full_o  = cnt_q == CNTW'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign entry_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

// File: rtl/sces_front.sv
// Front part: accepts pixels, converts to gray, runs the line stores and
// the 3x3 window, and queues one entry per emitted position.
// Depends on sces_pkg and sces_ram.
`timescale 1ns / 1ps
module sces_front import sces_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       push_i,
  input  logic [7:0] pix_red_i,
  input  logic [7:0] pix_green_i,
  input  logic [7:0] pix_blue_i,
  output logic       full_o,
  input  logic       q_full_i,
  output logic       q_push_o,
  output entry_t     q_entry_o
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [CW-1:0]        col_q;
  logic [11:0]          row_q;
  logic [23:0]          pix_q;
  logic [7:0]           gray_q;
  logic [2:0][2:0][7:0] win_q, win_d;
  logic [23:0]          centre_q;
  entry_t               entry_q, entry_d;

  logic        accept;
  logic [18:0] gray_sum;
  logic [7:0]  gray_d;
  logic [7:0]  up_rd, mid_rd;
  logic [23:0] color_rd;
  logic [13:0] w_raw, w_eff, col_ext;
  logic [11:0] h_eff;
  logic        col_last, row_last, emit;
  logic        calc;

  assign full_o = state_q != S_IDLE;
  assign accept = push_i && !full_o;
  assign calc   = state_q == S_CALC;

  assign gray_sum = 19'(cfg_i.weight_red) * 19'(pix_red_i)
                  + 19'(cfg_i.weight_green) * 19'(pix_green_i)
                  + 19'(cfg_i.weight_blue) * 19'(pix_blue_i);
  assign gray_d = (gray_sum[18:16] != 3'd0) ? 8'hFF : gray_sum[15:8];

  sces_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i, .we_i(calc), .waddr_i(col_q), .wdata_i(mid_rd),
    .re_i(accept), .raddr_i(col_q), .rdata_o(up_rd)
  );
  sces_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i, .we_i(calc), .waddr_i(col_q), .wdata_i(gray_q),
    .re_i(accept), .raddr_i(col_q), .rdata_o(mid_rd)
  );
  sces_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_color (
    .clk_i, .we_i(calc), .waddr_i(col_q), .wdata_i(pix_q),
    .re_i(accept), .raddr_i(col_q), .rdata_o(color_rd)
  );

  always_comb begin
    w_raw = {2'b00, cfg_i.image_width};
    if (w_raw < 14'd3) begin
      w_eff = 14'd3;
    end else if (w_raw > 14'(MAX_WIDTH)) begin
      w_eff = 14'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_eff    = (cfg_i.image_height < 12'd3) ? 12'd3 : cfg_i.image_height;
    col_ext  = 14'(col_q);
    col_last = (col_ext + 14'd1) >= w_eff;
    row_last = ({1'b0, row_q} + 13'd1) >= {1'b0, h_eff};
    emit     = (col_q != '0) && (row_q != '0);

    for (int k = 0; k < 3; k++) begin
      win_d[k][0] = win_q[k][1];
      win_d[k][1] = win_q[k][2];
    end
    win_d[0][2] = up_rd;
    win_d[1][2] = mid_rd;
    win_d[2][2] = gray_q;

    entry_d.win    = win_d;
    entry_d.color  = centre_q;
    entry_d.col    = 11'(col_ext - 14'd1);
    entry_d.row    = row_q - 12'd1;
    entry_d.done   = col_last && row_last;
    entry_d.border = (col_ext == 14'd1) || (row_q == 12'd1);

    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept) state_d = S_CALC;
      S_CALC: state_d = emit ? S_PUSH : S_IDLE;
      S_PUSH: if (!q_full_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign q_push_o  = (state_q == S_PUSH) && !q_full_i;
  assign q_entry_o = entry_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q  <= {pix_red_i, pix_green_i, pix_blue_i};
      gray_q <= gray_d;
    end
    if (calc) begin
      entry_q <= entry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      col_q    <= '0;
      row_q    <= '0;
      win_q    <= '0;
      centre_q <= '0;
    end else begin
      state_q <= state_d;
      if (calc) begin
        win_q    <= win_d;
        centre_q <= color_rd;
        if (col_last) begin
          col_q <= '0;
          row_q <= row_last ? 12'd0 : row_q + 12'd1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/sces_back.sv
// Back part: Sobel sums, iterative square root of half the squared norm,
// color scaling and the output register.
// Depends on sces_pkg.
`timescale 1ns / 1ps
module sces_back import sces_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  entry_t      q_entry_i,
  output logic        q_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [10:0] out_col_o,
  output logic [11:0] out_row_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        frame_done_o
);
  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_SUM  = 3'd1;
  localparam logic [2:0] B_SQ   = 3'd2;
  localparam logic [2:0] B_ADD  = 3'd3;
  localparam logic [2:0] B_ROOT = 3'd4;
  localparam logic [2:0] B_MUL  = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;

  logic [2:0]         state_q;
  entry_t             ent_q;
  logic signed [11:0] v_q, h_q;
  logic [19:0]        vv_q, hh_q;
  logic [19:0]        n_q, res_q, bit_q;
  logic [15:0]        pr_q, pg_q, pb_q;
  logic               out_valid_q;
  logic [7:0]         mag;
  logic [19:0]        trial;
  logic               slot_free;

  function automatic logic signed [11:0] tap(input logic [7:0] p);
    tap = signed'({4'd0, p});
  endfunction

  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = 17'(p) + 17'd1 + 17'(p[15:8]);
    div255 = t[15:8];
  endfunction

  assign q_pop_o   = (state_q == B_IDLE) && !q_empty_i;
  assign slot_free = !out_valid_q || pop_i;
  assign empty_o   = !out_valid_q;
  assign trial     = res_q + bit_q;
  assign mag       = ent_q.border ? 8'd0 : ((res_q > 20'd255) ? 8'hFF : res_q[7:0]);

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: if (!q_empty_i) ent_q <= q_entry_i;
      B_SUM: begin
        v_q <= tap(ent_q.win[0][0]) + (tap(ent_q.win[1][0]) <<< 1) + tap(ent_q.win[2][0])
             - tap(ent_q.win[0][2]) - (tap(ent_q.win[1][2]) <<< 1) - tap(ent_q.win[2][2]);
        h_q <= tap(ent_q.win[0][0]) + (tap(ent_q.win[0][1]) <<< 1) + tap(ent_q.win[0][2])
             - tap(ent_q.win[2][0]) - (tap(ent_q.win[2][1]) <<< 1) - tap(ent_q.win[2][2]);
      end
      B_SQ: begin
        vv_q <= 20'(unsigned'(24'(v_q) * 24'(v_q)));
        hh_q <= 20'(unsigned'(24'(h_q) * 24'(h_q)));
      end
      B_ADD: begin
        n_q   <= 20'((21'(vv_q) + 21'(hh_q)) >> 1);
        res_q <= '0;
        bit_q <= 20'd1 << 18;
      end
      B_ROOT: begin
        // one result bit per cycle
        if (n_q >= trial) begin
          n_q   <= n_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      B_MUL: begin
        pr_q <= ent_q.color[23:16] * mag;
        pg_q <= ent_q.color[15:8] * mag;
        pb_q <= ent_q.color[7:0] * mag;
      end
      default: ;
    endcase
    if (state_q == B_OUT && slot_free) begin
      out_col_o    <= ent_q.col;
      out_row_o    <= ent_q.row;
      out_red_o    <= div255(pr_q);
      out_green_o  <= div255(pg_q);
      out_blue_o   <= div255(pb_q);
      frame_done_o <= ent_q.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: if (!q_empty_i) state_q <= B_SUM;
        B_SUM:  state_q <= B_SQ;
        B_SQ:   state_q <= B_ADD;
        B_ADD:  state_q <= B_ROOT;
        B_ROOT: if (bit_q[1:0] != 2'd0) state_q <= B_MUL;
        B_MUL:  state_q <= B_OUT;
        B_OUT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/sobel_color_edge_stream_unit.sv
// Top level of the color Sobel edge stream: config registers, front, queue, back.
// Depends on sces_pkg, sces_front, sces_queue, sces_back (and sces_ram below).
`timescale 1ns / 1ps
// Raster-order RGB pixels go in through push/full; for each pixel at column
// x >= 1 and row y >= 1 one output pixel for (x-1, y-1) comes out through
// empty/pop, its centre color scaled by the Sobel magnitude of the gray image
// (black on the top row and left column). An accepted pixel holds the front
// through gray and line-store read, window update and, if it emits, a queue
// push that waits while the queue is full. The back runs one entry at a time
// through take, sums, squares, half sum, ten square-root steps, color
// multiply and output register (which waits for a free output slot); the
// square-root loop sets its sustained rate. The line stores are RAMs that are
// never cleared: their contents are only valid once a row has been written.
// Write config registers only while the block is idle.
module sobel_color_edge_stream_unit import sces_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  pix_red_i,
  input  logic [7:0]  pix_green_i,
  input  logic [7:0]  pix_blue_i,
  output logic        empty,
  input  logic        pop,
  output logic [10:0] out_col_o,
  output logic [11:0] out_row_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        frame_done_o
);
  cfg_t   cfg_q;
  logic   q_push, q_full, q_pop, q_empty;
  entry_t q_in, q_out;

  // hold config; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= WIDTH_RST;
      cfg_q.image_height <= HEIGHT_RST;
      cfg_q.weight_red   <= RED_RST;
      cfg_q.weight_green <= GREEN_RST;
      cfg_q.weight_blue  <= BLUE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  cfg_q.image_width  <= cfg_wdata_i;
        CFG_HEIGHT: cfg_q.image_height <= cfg_wdata_i;
        CFG_RED:    cfg_q.weight_red   <= cfg_wdata_i[8:0];
        CFG_GREEN:  cfg_q.weight_green <= cfg_wdata_i[8:0];
        CFG_BLUE:   cfg_q.weight_blue  <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  sces_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .push_i(push),
    .pix_red_i, .pix_green_i, .pix_blue_i, .full_o(full),
    .q_full_i(q_full), .q_push_o(q_push), .q_entry_o(q_in)
  );

  sces_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .entry_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .entry_o(q_out), .empty_o(q_empty)
  );

  sces_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_entry_i(q_out), .q_pop_o(q_pop),
    .pop_i(pop), .empty_o(empty), .out_col_o, .out_row_o, .out_red_o, .out_green_o,
    .out_blue_o, .frame_done_o
  );
endmodule
